// ----- design/dasg_pkg.sv -----
// dasg_pkg: shared types and constants for the discrete angle set generator.
// No dependencies.
package dasg_pkg;

    localparam int DIR_X_W = 7;
    localparam int DIR_Y_W = 8;
    localparam int POS_W   = 14;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0] CFG_KERNEL_RESET = 7'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_OUT
    } t_state;

endpackage

// ----- design/discrete_angle_set_generator.sv -----
// discrete_angle_set_generator: top level, sequencer around one shared serial divider
// and one shared multiply-subtract step. Depends on dasg_pkg.
//
// Usage:
//   Each request on the input channel (i_in_valid / o_in_ready, payload i_restart)
//   produces exactly one direction on the output channel (o_out_valid / i_out_ready,
//   payload o_dir_x, o_dir_y, o_position, o_last). The directions run over all coprime
//   pairs inside the K x K box by falling angle from (0,1) to (1,0), then back with dy
//   negated down to (1,-K), which carries o_last. The request after that starts over.
//   i_restart = 1 starts over at (0,1), position 0.
//   Box side K is written through i_cfg_wr_en / i_cfg_wr_data (clamped to
//   1..MAX_KERNEL); a write clears the sequence. Write only while the block is idle.
// Sequencing:
//   Requests that start over, and the step after (0,1), skip the divider and go
//   straight to the output state. Other steps run the serial restoring divider, one
//   quotient bit per cycle (NW = clog2(MAX_KERNEL+1)+1 bits, 8 for the default), once
//   for dx and once more for dy when dy != 0, then the multiply-subtract step for dx
//   and then for dy. One request is in flight at a time.
// Reset and stall:
//   Synchronous active-low reset sets K = 8 and clears the sequence; the output is
//   empty. The result register holds while the receiver stalls; the next request is
//   already accepted and computed meanwhile, and is loaded once the slot frees up.
module discrete_angle_set_generator #(
    parameter int MAX_KERNEL = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [dasg_pkg::CFG_W-1:0]          i_cfg_wr_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_restart,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [dasg_pkg::DIR_X_W-1:0]        o_dir_x,
    output logic signed [dasg_pkg::DIR_Y_W-1:0] o_dir_y,
    output logic [dasg_pkg::POS_W-1:0]          o_position,
    output logic                                o_last
);

    localparam int MW   = $clog2(MAX_KERNEL + 1);   // magnitude bits
    localparam int CW   = MW + 1;                    // signed component bits
    localparam int NW   = MW + 1;                    // dividend / quotient bits
    localparam int CNTW = $clog2(NW);
    localparam int PW   = NW + CW + 1;               // product bits

    localparam logic signed [CW-1:0] C_ZERO = '0;
    localparam logic signed [CW-1:0] C_ONE  = CW'(1);
    localparam logic [MW-1:0]        K_MAX  = MW'(MAX_KERNEL);

    dasg_pkg::t_state r_state, n_state;

    logic [dasg_pkg::CFG_W-1:0] r_kernel, n_kernel;
    logic signed [CW-1:0]       r_px, n_px, r_py, n_py;
    logic signed [CW-1:0]       r_cx, n_cx, r_cy, n_cy;
    logic signed [CW-1:0]       r_nx, n_nx, r_ny, n_ny;
    logic [dasg_pkg::POS_W-1:0] r_count, n_count;
    logic                       r_out_valid, n_out_valid;
    logic                       r_rst, n_rst;
    logic                       r_axis, n_axis;
    logic [MW-1:0]              r_rem, n_rem;
    logic [NW-1:0]              r_quo, n_quo;
    logic [NW-1:0]              r_k, n_k;
    logic [CNTW-1:0]            r_cnt, n_cnt;

    function automatic logic [MW-1:0] mag(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    // effective box side
    logic [MW-1:0]        w_k;
    logic signed [CW-1:0] w_ks;

    always_comb begin
        if (r_kernel == '0) begin
            w_k = MW'(1);
        end else if (9'(r_kernel) > 9'(MAX_KERNEL)) begin
            w_k = K_MAX;
        end else begin
            w_k = MW'(r_kernel);
        end
    end
    assign w_ks = signed'({1'b0, w_k});

    // sequence position tests
    logic w_unstarted, w_last, w_top;
    assign w_unstarted = (r_cx == C_ZERO) && (r_cy == C_ZERO);
    assign w_last      = (r_cx == C_ONE) && (r_cy == -w_ks);
    assign w_top       = (r_cx == C_ZERO) && (r_cy == C_ONE);

    // divider operands: dividend K + |u_c|, divisor |v_c|
    logic [NW-1:0] w_num_x, w_num_y;
    logic [MW-1:0] w_den;
    assign w_num_x = NW'(w_k) + NW'(mag(r_px));
    assign w_num_y = NW'(w_k) + NW'(mag(r_py));
    assign w_den   = r_axis ? mag(r_cy) : mag(r_cx);

    // one restoring division step
    logic [MW:0]   w_shift, w_sub;
    logic          w_ge;
    logic [MW-1:0] w_rem_step;
    logic [NW-1:0] w_quo_step;
    assign w_shift    = {r_rem, r_quo[NW-1]};
    assign w_ge       = w_shift >= {1'b0, w_den};
    assign w_sub      = w_shift - {1'b0, w_den};
    assign w_rem_step = w_ge ? w_sub[MW-1:0] : w_shift[MW-1:0];
    assign w_quo_step = {r_quo[NW-2:0], w_ge};

    // shared multiply-subtract: k * v_c - u_c
    logic signed [CW-1:0] w_v, w_u;
    logic signed [PW-1:0] w_kw, w_vw, w_prod, w_res;
    assign w_v    = r_axis ? r_cy : r_cx;
    assign w_u    = r_axis ? r_py : r_px;
    assign w_kw   = signed'(PW'(r_k));
    assign w_vw   = PW'(w_v);
    assign w_prod = w_kw * w_vw;
    assign w_res  = w_prod - PW'(w_u);

    always_comb begin
        n_state     = r_state;
        n_kernel    = r_kernel;
        n_px        = r_px;
        n_py        = r_py;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_nx        = r_nx;
        n_ny        = r_ny;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        n_rst       = r_rst;
        n_axis      = r_axis;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_k         = r_k;
        n_cnt       = r_cnt;

        case (r_state)
            dasg_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_restart || w_unstarted || w_last || (r_cx == C_ZERO && !w_top)) begin
                        n_rst   = 1'b1;
                        n_state = dasg_pkg::S_OUT;
                    end else if (w_top) begin
                        // (0,1) is always followed by (1,K)
                        n_rst   = 1'b0;
                        n_nx    = C_ONE;
                        n_ny    = w_ks;
                        n_state = dasg_pkg::S_OUT;
                    end else begin
                        n_rst   = 1'b0;
                        n_axis  = 1'b0;
                        n_rem   = '0;
                        n_quo   = w_num_x;
                        n_cnt   = CNTW'(NW - 1);
                        n_state = dasg_pkg::S_DIV;
                    end
                end
            end
            dasg_pkg::S_DIV: begin
                n_rem = w_rem_step;
                n_quo = w_quo_step;
                n_cnt = r_cnt - CNTW'(1);
                if (r_cnt == '0) begin
                    // k is the smaller quotient of the two axes
                    if (!r_axis || w_quo_step < r_k) begin
                        n_k = w_quo_step;
                    end
                    if (!r_axis && r_cy != C_ZERO) begin
                        n_axis = 1'b1;
                        n_rem  = '0;
                        n_quo  = w_num_y;
                        n_cnt  = CNTW'(NW - 1);
                    end else begin
                        n_axis  = 1'b0;
                        n_state = dasg_pkg::S_MUL;
                    end
                end
            end
            dasg_pkg::S_MUL: begin
                if (!r_axis) begin
                    n_nx   = w_res[CW-1:0];
                    n_axis = 1'b1;
                end else begin
                    n_ny    = w_res[CW-1:0];
                    n_axis  = 1'b0;
                    n_state = dasg_pkg::S_OUT;
                end
            end
            dasg_pkg::S_OUT: begin
                // load the result slot once it is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_state     = dasg_pkg::S_IDLE;
                    if (r_rst) begin
                        n_px    = C_ZERO;
                        n_py    = C_ZERO;
                        n_cx    = C_ZERO;
                        n_cy    = C_ONE;
                        n_count = '0;
                    end else begin
                        n_px    = r_cx;
                        n_py    = r_cy;
                        n_cx    = r_nx;
                        n_cy    = r_ny;
                        n_count = r_count + 1'b1;
                    end
                end
            end
            default: begin
                n_state = dasg_pkg::S_IDLE;
            end
        endcase

        // register write clears the sequence
        if (i_cfg_wr_en) begin
            n_kernel = i_cfg_wr_data;
            n_px     = C_ZERO;
            n_py     = C_ZERO;
            n_cx     = C_ZERO;
            n_cy     = C_ZERO;
            n_count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dasg_pkg::S_IDLE;
            r_kernel    <= dasg_pkg::CFG_KERNEL_RESET;
            r_px        <= C_ZERO;
            r_py        <= C_ZERO;
            r_cx        <= C_ZERO;
            r_cy        <= C_ZERO;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_rst       <= 1'b0;
            r_axis      <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_kernel    <= n_kernel;
            r_px        <= n_px;
            r_py        <= n_py;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_rst       <= n_rst;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_nx  <= n_nx;
        r_ny  <= n_ny;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_k   <= n_k;
    end

    // outputs come straight from the current direction, masked to field width
    logic signed [31:0] w_cx32, w_cy32;
    assign w_cx32 = 32'(r_cx);
    assign w_cy32 = 32'(r_cy);

    assign o_in_ready  = (r_state == dasg_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_dir_x     = w_cx32[dasg_pkg::DIR_X_W-1:0];
    assign o_dir_y     = signed'(w_cy32[dasg_pkg::DIR_Y_W-1:0]);
    assign o_position  = r_count;
    assign o_last      = w_last;

endmodule
